### src/text_console_character_engine_defines.svh
// ----------------------------------------------------------------------------
// text_console_character_engine_defines
// Assertion macros used by the console character engine RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Geometry, codes and beat types of the text console character engine.
// ----------------------------------------------------------------------------
package tce_pkg;

    // screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STEP = 8;
    localparam int CELLS    = COLUMNS * ROWS;

    // field widths
    localparam int ADDR_W = 11;                 // cursor_pos / cell_index
    localparam int MEM_AW = $clog2(CELLS);      // frame memory address
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int PH_W   = 4;                  // column modulo tab step
    localparam int CFG_IW = 1;

    localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0F20;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_FG = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_BG = 1'd1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_index;
    } t_in_beat;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor_pos;
        logic [CELL_W-1:0] cell_value;
    } t_out_beat;

    // cursor unit status toward the sequencer
    typedef struct packed {
        logic [MEM_AW-1:0] lin;        // row*COLUMNS+col
        logic              printable;  // current char writes a cell
        logic              scroll;     // current char runs past the last row
    } t_cur_info;

endpackage

### src/tce_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_frame_mem
// Frame memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tce_frame_mem
    import tce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [MEM_AW-1:0] i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic [MEM_AW-1:0] i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/tce_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_cursor
// Cursor registers and the put-character cursor update.
// ----------------------------------------------------------------------------
module tce_cursor
    import tce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_char,
    output t_cur_info         o_cur
);

    localparam int CSUM_W = COL_W + 1;

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [PH_W-1:0]   r_phase, n_phase;   // r_col mod TAB_STEP
    logic [CSUM_W-1:0] col_sum;
    logic              row_inc;
    logic              printable;
    logic              scroll;

    assign printable = (i_char >= CH_SPACE) && (i_char <= CH_PRINT_MAX);

    always_comb begin
        n_row   = r_row;
        n_phase = r_phase;
        col_sum = {1'b0, r_col};
        row_inc = 1'b0;
        priority if (i_char == CH_BACKSPACE) begin
            if (r_col != '0) begin
                col_sum = {1'b0, r_col} - 1'b1;
                n_phase = (r_phase == '0) ? PH_W'(TAB_STEP - 1) : r_phase - 1'b1;
            end
        end else if (i_char == CH_TAB) begin
            col_sum = {1'b0, r_col} + CSUM_W'(TAB_STEP) - CSUM_W'(r_phase);
            n_phase = '0;
        end else if (i_char == CH_RETURN) begin
            col_sum = '0;
            n_phase = '0;
        end else if (i_char == CH_NEWLINE) begin
            col_sum = '0;
            n_phase = '0;
            row_inc = 1'b1;
        end else if (printable) begin
            col_sum = {1'b0, r_col} + 1'b1;
            n_phase = (r_phase == PH_W'(TAB_STEP - 1)) ? '0 : r_phase + 1'b1;
        end else begin
            col_sum = {1'b0, r_col};
        end
        // column limit wraps
        if (int'(col_sum) >= COLUMNS) begin
            n_col   = '0;
            n_phase = '0;
            row_inc = 1'b1;
        end else begin
            n_col = col_sum[COL_W-1:0];
        end
        // on the last row the frame scrolls and the row stays
        scroll = row_inc && (int'(r_row) == ROWS - 1);
        if (row_inc && !scroll) begin
            n_row = r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (i_step) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
        end
    end

    assign o_cur.lin       = MEM_AW'(int'(r_row) * COLUMNS + int'(r_col));
    assign o_cur.printable = printable;
    assign o_cur.scroll    = scroll;

endmodule

### src/text_console_character_engine.sv
`timescale 1ns / 1ps
`include "text_console_character_engine_defines.svh"
// ----------------------------------------------------------------------------
// text_console_character_engine
// Text console: put-char, clear and read-cell over a frame memory of cells.
// ----------------------------------------------------------------------------
// Usage
//   Command beat: drive i_in (op, char_code, cell_index) with i_start; it is
//   taken at a rising edge where i_start is high and o_busy is low.
//   Result beat: o_out (cursor_pos, cell_value) is shown for exactly one
//   cycle with o_valid. The receiver cannot stall; every command gives one
//   result beat.
//   Colors: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 fg, 1 bg)
//   at the edge, no wait. Write them only while the block is idle.
// Timing
//   Put (no scroll), read, unused op: the command passes through the exec
//   and done states, then the result register raises o_valid; a new
//   command is taken only once the state is back to idle.
//   Clear and scrolling put: one sweep of the frame memory, one cell per
//   cycle through the single write port, before the result beat.
// Reset
//   Synchronous, active low. After reset a clearing pass writes blank
//   cells (0x0F20) to the whole frame, with o_busy high; color writes are
//   still taken meanwhile.
// ----------------------------------------------------------------------------
module text_console_character_engine
    import tce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in_beat          i_in,
    output logic              o_busy,
    output logic              o_valid,
    output t_out_beat         o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CLR_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // latched command
    t_op               r_op;
    logic [CHAR_W-1:0] r_char;
    logic [ADDR_W-1:0] r_idx;
    logic              r_rd_ok;

    // colors
    logic [CLR_W-1:0] r_fg;
    logic [CLR_W-1:0] r_bg;

    // sweep unit: one pointer walks the frame, the write follows in the next cycle
    logic [MEM_AW-1:0] r_ptr;
    logic              r_copy;      // scroll: copy from the row below
    logic              r_reply;     // send a result when the sweep ends
    logic [CELL_W-1:0] r_blank;
    logic              r_wr_pend;
    logic [MEM_AW-1:0] r_wr_addr;
    logic              r_wr_copy;

    // result beat
    logic      r_valid;
    t_out_beat r_out;

    // memory ports
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [MEM_AW-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic      cur_step;
    t_cur_info cur;
    int        src_addr;
    logic      idx_ok;
    logic      sweep_last;

    assign cur_step   = (r_state == S_EXEC) && (r_op == OP_PUT);
    assign src_addr   = int'(r_ptr) + COLUMNS;
    assign idx_ok     = int'(r_idx) < CELLS;
    assign sweep_last = int'(r_ptr) == CELLS - 1;

    tce_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (cur_step),
        .i_char  (r_char),
        .o_cur   (cur)
    );

    tce_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // write port: lagging sweep write, else a printable character
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = r_wr_copy ? mem_rdata : r_blank;
        priority if (r_wr_pend) begin
            mem_we = 1'b1;
        end else if (cur_step && cur.printable) begin
            mem_we    = 1'b1;
            mem_waddr = cur.lin;
            mem_wdata = {r_bg, r_fg, r_char};
        end else begin
            mem_we = 1'b0;
        end
    end

    // read port: row below during a sweep, requested cell on exec
    always_comb begin
        mem_raddr = '0;
        if (r_state == S_SWEEP && src_addr < CELLS) begin
            mem_raddr = MEM_AW'(src_addr);
        end else if (r_state == S_EXEC && idx_ok) begin
            mem_raddr = MEM_AW'(r_idx);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((r_op == OP_CLEAR) || (r_op == OP_PUT && cur.scroll)) begin
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (sweep_last) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_ptr     <= '0;
            r_copy    <= 1'b0;
            r_reply   <= 1'b0;
            r_blank   <= RESET_BLANK;
            r_wr_pend <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= r_state == S_DONE;
            r_wr_pend <= r_state == S_SWEEP;
            if (r_state == S_EXEC) begin
                r_ptr   <= '0;
                r_copy  <= r_op == OP_PUT;
                r_reply <= 1'b1;
                r_blank <= {r_bg, r_fg, CH_SPACE};
            end else if (r_state == S_SWEEP) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    // color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'hF;
            r_bg <= 4'h0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FG:  r_fg <= i_cfg_data;
                CFG_BG:  r_bg <= i_cfg_data;
                default: r_fg <= r_fg;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op   <= t_op'(i_in.op);
            r_char <= i_in.char_code;
            r_idx  <= i_in.cell_index;
        end
        if (r_state == S_EXEC) begin
            r_rd_ok <= (r_op == OP_READ) && idx_ok;
        end
        if (r_state == S_SWEEP) begin
            r_wr_addr <= r_ptr;
            r_wr_copy <= r_copy && (int'(r_ptr) < CELLS - COLUMNS);
        end
        if (r_state == S_DONE) begin
            r_out.cursor_pos <= ADDR_W'(cur.lin);
            r_out.cell_value <= r_rd_ok ? mem_rdata : '0;
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_valid;
    assign o_out   = r_out;

    `TCE_ASSERT_NXT(a_accept_exec, i_start && !o_busy, r_state == S_EXEC,
        "accepted command beat did not enter exec")
    `TCE_ASSERT_NXT(a_done_valid, r_state == S_DONE, o_valid && !o_busy,
        "result beat missing after done")
    `TCE_ASSERT_NXT(a_scroll_sweep, cur_step && cur.scroll, r_state == S_SWEEP,
        "scroll did not start a frame sweep")
    `TCE_ASSERT_IMP(a_wr_in_frame, mem_we, int'(mem_waddr) < CELLS,
        "frame memory write outside the frame")

endmodule
